### rtl/ldw_pkg.sv
// Shared types and constants for the decimal LCD writer.
package ldw_pkg;

	localparam int VALUE_W      = 32;
	localparam int COLUMN_W     = 6;
	localparam int BYTE_W       = 8;
	localparam int DIGIT_W      = 4;
	localparam int MAX_DIGITS_DEF = 10;

	// HD44780 bus codes.
	localparam logic [BYTE_W-1:0] CMD_SET_ADDR = 8'h80;
	localparam logic [BYTE_W-1:0] ROW1_OFFSET  = 8'h40;
	localparam logic [BYTE_W-1:0] ASCII_ZERO   = 8'h30;

	// Shift-and-add-3 correction.
	localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
	localparam logic [DIGIT_W-1:0] DABBLE_ADJ   = 4'd3;

	typedef logic [DIGIT_W-1:0] digit_t;

	typedef struct packed {
		logic [VALUE_W-1:0]  value;
		logic                row;
		logic [COLUMN_W-1:0] column;
	} ldw_req_t;

	typedef struct packed {
		logic              is_data;
		logic [BYTE_W-1:0] bus_byte;
		logic              last;
	} ldw_wr_t;

	// Per-cycle command broadcast to every digit cell.
	typedef struct packed {
		logic clear;
		logic dabble;
		logic hand_down;
	} ldw_cell_ctl_t;

endpackage

### rtl/ldw_stream_if.sv
// Valid/ready stream channel with a typed payload.
interface ldw_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### rtl/ldw_digit_cell.sv
// One BCD digit cell of the shift-and-add-3 chain.
module ldw_digit_cell import ldw_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  ldw_cell_ctl_t ctl,
	input  logic          carry_in,
	input  digit_t        upper_digit,
	output logic          carry_out,
	output digit_t        digit
);

	digit_t digit_q;
	digit_t adj;

	// Add 3 when the digit would reach ten or more after the shift.
	assign adj       = (digit_q >= DABBLE_LIMIT) ? digit_q + DABBLE_ADJ : digit_q;
	assign carry_out = adj[DIGIT_W-1];
	assign digit     = digit_q;

	// Shift a bit in from below, or take the digit from the cell above.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else if (ctl.clear) begin
			digit_q <= '0;
		end else if (ctl.dabble) begin
			digit_q <= {adj[DIGIT_W-2:0], carry_in};
		end else if (ctl.hand_down) begin
			digit_q <= upper_digit;
		end
	end

endmodule

### rtl/lcd_decimal_integer_writer_unit.sv
// Top level: binary to decimal conversion and LCD bus write sequencing.
//
//  channel | dir | payload                          | handshake
//  num     | in  | value[31:0], row, column[5:0]    | valid/ready
//  bus     | out | is_data, bus_byte[7:0], last     | valid/ready
//
// One value is accepted, converted through the digit-cell chain (one bit
// per cycle), then its digit count is found, then each digit is written
// as an address command followed by its character. A stalled output
// holds its beat in the output register and pauses the sequencer. Reset
// clears the sequencer and the output valid; no clearing pass is needed.
module lcd_decimal_integer_writer_unit import ldw_pkg::*; #(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	ldw_stream_if.sink   num,
	ldw_stream_if.source bus
);

	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam int BIT_W = $clog2(VALUE_W);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CONV  = 5'b00010,
		ST_COUNT = 5'b00100,
		ST_CMD   = 5'b01000,
		ST_DATA  = 5'b10000
	} state_t;

	state_t             state_q;
	logic [VALUE_W-1:0] value_q;
	logic [BYTE_W-1:0]  base_q;
	logic [BIT_W-1:0]   bit_cnt_q;
	logic               ovf_q;
	logic [CNT_W-1:0]   rem_q;
	logic [CNT_W-1:0]   count;
	logic               bus_valid_q;
	ldw_wr_t            bus_data_q;

	ldw_cell_ctl_t      cell_ctl;
	logic [MAX_DIGITS:0]   carry;
	digit_t             digits [MAX_DIGITS];
	digit_t             uppers [MAX_DIGITS];

	logic accept;
	logic out_free;
	logic emit;

	assign accept   = num.valid && num.ready;
	assign num.ready = (state_q == ST_IDLE);
	assign out_free = !bus_valid_q || bus.ready;
	assign emit     = out_free && ((state_q == ST_CMD) || (state_q == ST_DATA));

	assign bus.valid = bus_valid_q;
	assign bus.data  = bus_data_q;

	// Cell commands.
	always_comb begin
		cell_ctl.clear     = accept;
		cell_ctl.dabble    = (state_q == ST_CONV);
		cell_ctl.hand_down = emit && (state_q == ST_DATA);
	end

	// Chain of digit cells, least significant at index 0.
	assign carry[0] = value_q[VALUE_W-1];
	for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_cell
		if (k == MAX_DIGITS - 1) begin : g_top
			assign uppers[k] = '0;
		end else begin : g_mid
			assign uppers[k] = digits[k+1];
		end
		ldw_digit_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (cell_ctl),
			.carry_in    (carry[k]),
			.upper_digit (uppers[k]),
			.carry_out   (carry[k+1]),
			.digit       (digits[k])
		);
	end

	// Digit count: highest nonzero digit, at least one, all cells on overflow.
	always_comb begin
		count = CNT_W'(1);
		for (int k = 0; k < MAX_DIGITS; k++) begin
			if (digits[k] != '0) begin
				count = CNT_W'(k + 1);
			end
		end
		if (ovf_q) begin
			count = CNT_W'(MAX_DIGITS);
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bit_cnt_q <= '0;
			ovf_q     <= 1'b0;
			rem_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						bit_cnt_q <= '0;
						ovf_q     <= 1'b0;
						state_q   <= ST_CONV;
					end
				end
				ST_CONV: begin
					bit_cnt_q <= bit_cnt_q + 1'b1;
					ovf_q     <= ovf_q | carry[MAX_DIGITS];
					if (bit_cnt_q == BIT_W'(VALUE_W - 1)) begin
						state_q <= ST_COUNT;
					end
				end
				ST_COUNT: begin
					rem_q   <= count;
					state_q <= ST_CMD;
				end
				ST_CMD: begin
					if (out_free) begin
						state_q <= ST_DATA;
					end
				end
				ST_DATA: begin
					if (out_free) begin
						rem_q   <= rem_q - 1'b1;
						state_q <= (rem_q == CNT_W'(1)) ? ST_IDLE : ST_CMD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Input value shift register and address base.
	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= num.data.value;
			base_q  <= CMD_SET_ADDR + (num.data.row ? ROW1_OFFSET : '0)
				+ BYTE_W'(num.data.column);
		end else if (state_q == ST_CONV) begin
			value_q <= {value_q[VALUE_W-2:0], 1'b0};
		end
	end

	// Output register: holds a beat until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_valid_q <= 1'b0;
		end else if (emit) begin
			bus_valid_q <= 1'b1;
		end else if (bus.ready) begin
			bus_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (state_q == ST_CMD) begin
				bus_data_q.is_data  <= 1'b0;
				bus_data_q.bus_byte <= base_q + BYTE_W'(rem_q - 1'b1);
				bus_data_q.last     <= 1'b0;
			end else begin
				bus_data_q.is_data  <= 1'b1;
				bus_data_q.bus_byte <= ASCII_ZERO + BYTE_W'(digits[0]);
				bus_data_q.last     <= (rem_q == CNT_W'(1));
			end
		end
	end

endmodule

### tb/lcd_bus_write_checker.sv
// Checker for the decimal LCD writer: predicts every bus write and compares it.
`timescale 1ns / 1ps

module lcd_bus_write_checker import ldw_pkg::*; #(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        num_valid,
	input  logic        num_ready,
	input  ldw_req_t    num_data,
	input  logic        bus_valid,
	input  logic        bus_ready,
	input  ldw_wr_t     bus_data,
	input  logic        run_over,
	output int unsigned fail_count,
	output int unsigned pending_writes,
	output int unsigned values_seen,
	output int unsigned writes_checked
);

	localparam int DIGIT_SLOTS  = 20;
	localparam int DIGIT_CAP    = (MAX_DIGITS > DIGIT_SLOTS) ? DIGIT_SLOTS :
		(MAX_DIGITS < 1) ? 1 : MAX_DIGITS;
	localparam int DECIMAL_BASE = 10;
	localparam int REPORT_CAP   = 30;

	// Bus writes still owed by the block, oldest first.
	ldw_wr_t expected_writes[$];
	bit      leftovers_flagged = 1'b0;

	initial begin
		fail_count     = 0;
		pending_writes = 0;
		values_seen    = 0;
		writes_checked = 0;
	end

	// Prints one line per mismatch (up to a cap) and always counts it.
	task automatic report_mismatch(input string msg);
		if (fail_count < REPORT_CAP) begin
			$display("[%0t] MISMATCH: %s", $time, msg);
		end
		fail_count++;
	endtask

	// Splits the value into decimal digits and queues the address/character
	// pairs, least significant digit first, the top digit landing at column.
	function automatic void queue_lcd_writes(input ldw_req_t req);
		digit_t             digits[DIGIT_SLOTS];
		int unsigned        count;
		logic [VALUE_W-1:0] rest;
		logic [BYTE_W-1:0]  base_addr;
		ldw_wr_t            wr;
		count = 0;
		rest  = req.value;
		do begin
			digits[count] = digit_t'(rest % DECIMAL_BASE);
			rest = rest / DECIMAL_BASE;
			count++;
		end while (rest != 0 && count < DIGIT_CAP);
		base_addr = CMD_SET_ADDR + (req.row ? ROW1_OFFSET : BYTE_W'(0)) + BYTE_W'(req.column);
		for (int unsigned i = 0; i < count; i++) begin
			wr.is_data  = 1'b0;
			wr.bus_byte = base_addr + BYTE_W'(count - 1 - i);
			wr.last     = 1'b0;
			expected_writes.push_back(wr);
			wr.is_data  = 1'b1;
			wr.bus_byte = ASCII_ZERO + BYTE_W'(digits[i]);
			wr.last     = (i + 1 == count);
			expected_writes.push_back(wr);
		end
	endfunction

	// Sample both channels at each rising edge.
	always @(posedge clk) begin
		ldw_wr_t want;
		if (arst_n) begin
			if (num_valid && num_ready) begin
				queue_lcd_writes(num_data);
				values_seen++;
			end
			if (bus_valid && bus_ready) begin
				if (expected_writes.size() == 0) begin
					report_mismatch($sformatf("unexpected write is_data=%0b byte=%02h last=%0b",
						bus_data.is_data, bus_data.bus_byte, bus_data.last));
				end else begin
					want = expected_writes.pop_front();
					writes_checked++;
					if (bus_data.is_data !== want.is_data) begin
						report_mismatch($sformatf("write %0d: is_data %0b, expected %0b",
							writes_checked, bus_data.is_data, want.is_data));
					end
					if (bus_data.bus_byte !== want.bus_byte) begin
						report_mismatch($sformatf("write %0d: bus_byte %02h, expected %02h",
							writes_checked, bus_data.bus_byte, want.bus_byte));
					end
					if (bus_data.last !== want.last) begin
						report_mismatch($sformatf("write %0d: last %0b, expected %0b",
							writes_checked, bus_data.last, want.last));
					end
				end
			end
			// Anything still owed once the run is over never arrived.
			if (run_over && !leftovers_flagged) begin
				foreach (expected_writes[k]) begin
					report_mismatch($sformatf("missing write is_data=%0b byte=%02h last=%0b",
						expected_writes[k].is_data, expected_writes[k].bus_byte,
						expected_writes[k].last));
				end
				leftovers_flagged = 1'b1;
			end
		end
		pending_writes = expected_writes.size();
	end

endmodule

### tb/lcd_decimal_integer_writer_unit_tb.sv
// Testbench top for the decimal LCD writer: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module lcd_decimal_integer_writer_unit_tb;
	import ldw_pkg::*;

	localparam int IDLE_LIMIT    = 4000;
	localparam int RANDOM_VALUES = 290;
	localparam int DRAIN_CYCLES  = 64;
	localparam int DECIMAL_BASE  = 10;

	typedef enum int unsigned {
		ALWAYS_READY,
		MOSTLY_READY,
		RARELY_READY,
		LONG_STALLS
	} ready_mode_t;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        src_valid  = 1'b0;
	ldw_req_t    src_data   = '0;
	logic        sink_ready = 1'b0;
	logic        run_over   = 1'b0;
	bit          no_gaps    = 1'b0;
	int unsigned burst_left = 0;
	int unsigned idle_cycles = 0;
	int unsigned stall_left  = 0;
	int unsigned mode_cycles = 0;
	ready_mode_t ready_mode  = ALWAYS_READY;

	int unsigned fail_count;
	int unsigned pending_writes;
	int unsigned values_seen;
	int unsigned writes_checked;

	ldw_stream_if #(.T(ldw_req_t)) num_ch ();
	ldw_stream_if #(.T(ldw_wr_t))  bus_ch ();

	assign num_ch.valid = src_valid;
	assign num_ch.data  = src_data;
	assign bus_ch.ready = sink_ready;

	always #1 clk = ~clk;

	lcd_decimal_integer_writer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.num    (num_ch),
		.bus    (bus_ch)
	);

	lcd_bus_write_checker bus_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.num_valid      (num_ch.valid),
		.num_ready      (num_ch.ready),
		.num_data       (num_ch.data),
		.bus_valid      (bus_ch.valid),
		.bus_ready      (bus_ch.ready),
		.bus_data       (bus_ch.data),
		.run_over       (run_over),
		.fail_count     (fail_count),
		.pending_writes (pending_writes),
		.values_seen    (values_seen),
		.writes_checked (writes_checked)
	);

	// Receiver: the stall style changes whenever its mode counter runs out.
	always @(posedge clk) begin
		if (mode_cycles == 0) begin
			ready_mode  <= ready_mode_t'($urandom_range(0, 3));
			mode_cycles <= $urandom_range(50, 300);
		end else begin
			mode_cycles <= mode_cycles - 1;
		end
		if (stall_left != 0) begin
			sink_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			case (ready_mode)
				ALWAYS_READY: sink_ready <= 1'b1;
				MOSTLY_READY: sink_ready <= ($urandom_range(0, 9) < 7);
				RARELY_READY: sink_ready <= ($urandom_range(0, 9) < 2);
				default: begin
					sink_ready <= 1'b1;
					if ($urandom_range(0, 15) == 0) begin
						stall_left <= $urandom_range(10, 40);
					end
				end
			endcase
		end
	end

	// Watchdog: ends the run if no beat moves on either channel for too long.
	always @(posedge clk) begin
		if ((num_ch.valid && num_ch.ready) || (bus_ch.valid && bus_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Watchdog: no beat for %0d cycles", IDLE_LIMIT);
			$display("lcd_decimal_integer_writer_unit regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Sends one value; between bursts, unless gaps are off, the sender drops valid for a random gap.
	task automatic send_value(input logic [VALUE_W-1:0] value, input logic row,
		input logic [COLUMN_W-1:0] column);
		int unsigned gap;
		if (burst_left != 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 7);
			if (!no_gaps) begin
				gap = $urandom_range(1, 6);
				src_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		src_data  <= '{value: value, row: row, column: column};
		src_valid <= 1'b1;
		@(posedge clk);
		while (!num_ch.ready) @(posedge clk);
	endtask

	// Mostly a uniform digit count, with some zeros and some raw 32-bit patterns.
	function automatic logic [VALUE_W-1:0] pick_value();
		longint unsigned lo;
		longint unsigned hi;
		int unsigned     pick;
		int unsigned     digits_wanted;
		pick = $urandom_range(0, 19);
		if (pick == 0) return '0;
		if (pick < 4) return $urandom;
		digits_wanted = $urandom_range(1, 10);
		lo = 1;
		repeat (digits_wanted - 1) lo = lo * DECIMAL_BASE;
		hi = lo * DECIMAL_BASE - 1;
		if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
		return VALUE_W'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
	endfunction

	initial begin
		logic [COLUMN_W-1:0] column;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: zero, digit-count boundaries, full range, both rows,
		// columns past the visible area and address wrap past 0xFF.
		send_value(32'd0,          1'b0, 6'd0);
		send_value(32'd0,          1'b1, 6'd63);
		send_value(32'd1,          1'b0, 6'd0);
		send_value(32'd9,          1'b1, 6'd5);
		send_value(32'd10,         1'b0, 6'd38);
		send_value(32'd99,         1'b1, 6'd39);
		send_value(32'd100,        1'b0, 6'd40);
		send_value(32'd12345,      1'b1, 6'd50);
		send_value(32'd999999999,  1'b0, 6'd20);
		send_value(32'd1000000000, 1'b1, 6'd30);
		send_value(32'hFFFF_FFFF,  1'b0, 6'd0);
		send_value(32'hFFFF_FFFF,  1'b1, 6'd63);
		send_value(32'hFFFF_FFFE,  1'b1, 6'd39);
		send_value(32'h8000_0000,  1'b0, 6'd12);
		send_value(32'h5555_5555,  1'b1, 6'd42);
		send_value(32'hAAAA_AAAA,  1'b0, 6'd1);
		send_value(32'd7,          1'b1, 6'd63);
		send_value(32'd65535,      1'b0, 6'd33);
		send_value(32'd4000000000, 1'b1, 6'd0);
		send_value(32'd2147483647, 1'b0, 6'd63);

		// Random values; every so often the sender runs back to back.
		for (int n = 0; n < RANDOM_VALUES; n++) begin
			if (n % 40 == 39) no_gaps = ~no_gaps;
			column = ($urandom_range(0, 9) == 0) ? COLUMN_W'($urandom_range(40, 63))
				: COLUMN_W'($urandom_range(0, 39));
			send_value(pick_value(), 1'($urandom_range(0, 1)), column);
		end
		src_valid <= 1'b0;

		// Drain, then give the block time to show any stray write.
		@(posedge clk);
		while (pending_writes != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		run_over <= 1'b1;
		repeat (2) @(posedge clk);

		$display("Summary: %0d values written (%0d random), %0d bus writes checked.",
			values_seen, RANDOM_VALUES, writes_checked);
		$display("Summary: both rows, columns 0 to 63 with address wrap, zero and ten-digit values.");
		if (fail_count == 0) begin
			$display("lcd_decimal_integer_writer_unit regression: pass");
		end else begin
			$display("lcd_decimal_integer_writer_unit regression: fail");
		end
		$finish;
	end

endmodule

### lcd_decimal_integer_writer_unit.f
rtl/ldw_pkg.sv
rtl/ldw_stream_if.sv
rtl/ldw_digit_cell.sv
rtl/lcd_decimal_integer_writer_unit.sv
tb/lcd_bus_write_checker.sv
tb/lcd_decimal_integer_writer_unit_tb.sv
